// File: design/hcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_pkg - shared types and constants of the Hill cipher block
// Character codes, status codes, register indexes and the job record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int KEY_DIM   = 3;           // key matrix is KEY_DIM x KEY_DIM
    localparam int CODE_W    = 5;           // letter code A=0 .. Z=25
    localparam int KEY_W     = KEY_DIM * KEY_DIM * CODE_W;
    localparam int ROW_W     = KEY_DIM * CODE_W;
    localparam int CFG_W     = KEY_W;
    localparam int ACC_W     = 12;          // 3 * 31 * 25 fits
    localparam int PROD_W    = 2 * CODE_W;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS   = 8'h20;
    localparam logic [CODE_W-1:0] PAD_CODE = 5'd23;   // 'X'
    localparam logic [6:0] LETTER_BASE = 7'h41;

    // floor(x / 26) == (x * 2521) >> 16 for all x below 2^12
    localparam logic [23:0] RECIP_26 = 24'd2521;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_BAD_LEN  = 2'd2;

    localparam logic [1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] REG_ENC_KEY    = 2'd1;
    localparam logic [1:0] REG_DEC_KEY    = 2'd2;

    localparam logic [1:0]       RST_BLOCK_SIZE = 2'd3;
    localparam logic [KEY_W-1:0] RST_KEY        = 45'h100_0010_0001;   // identity

    typedef struct packed {
        logic                           is_err;
        logic [1:0]                     status;
        logic                           mode;
        logic                           last;
        logic [1:0]                     n;
        logic [KEY_DIM-1:0][CODE_W-1:0] vec;
    } hcb_job_t;

endpackage
`default_nettype wire

// File: design/hill_cipher_block.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hill_cipher_block - Hill cipher modulo 26, one character per transfer
// Stream in ASCII characters, stream out cipher or plain letters.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one character (s_tdata), the mode in
// s_tuser (0 encrypt, 1 decrypt) and end of message in s_tlast. Letters are
// grouped into blocks of block_size (0 acts as 1) and each block vector is
// multiplied by the 5-bit-per-entry key matrix, reduced modulo 26. Encrypt
// folds lowercase and pads a short final block with X; decrypt takes
// uppercase only, and a short final block gives a length error. A bad
// character gives one error result and the rest of the message is dropped
// up to its last character. The block takes one character per cycle while the
// queue has room; a block of n letters leaves as n results, one per cycle unless
// m_tready stalls, so a padded final block makes up to three results from one
// transfer and a four-entry job queue absorbs the burst. Output throughput is
// one result per clock unless stalled, set by the single row engine. Characters
// pass queue write, dot product stage and modulo/output register. The user must
// write configuration only while idle (unenforced); no init sweep after reset.
// ----------------------------------------------------------------------------
module hill_cipher_block (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // configuration write port
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_addr,
    input  wire logic [hcb_pkg::CFG_W-1:0] cfg_wdata,
    // character input
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] char_in
    input  wire logic                      s_tuser,   // [0] mode
    input  wire logic                      s_tlast,   // msg_last
    // result output
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [7:0]                     m_tdata,   // [6:0] letter_out, [7] run_last
    output logic [1:0]                     m_tuser,   // [1:0] status
    output logic                           m_tlast    // msg_end
);
    import hcb_pkg::*;

    // Configuration registers
    logic [1:0]       blk_size_reg;
    logic [KEY_W-1:0] enc_key_reg;
    logic [KEY_W-1:0] dec_key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_size_reg <= RST_BLOCK_SIZE;
            enc_key_reg  <= RST_KEY;
            dec_key_reg  <= RST_KEY;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_BLOCK_SIZE: blk_size_reg <= cfg_wdata[1:0];
                REG_ENC_KEY:    enc_key_reg  <= cfg_wdata[KEY_W-1:0];
                REG_DEC_KEY:    dec_key_reg  <= cfg_wdata[KEY_W-1:0];
                default:        ;  // unmapped index, write ignored
            endcase
        end
    end

    // Front end: intake and block assembly
    logic     in_xfer;
    logic     job_push;
    hcb_job_t push_job;
    logic     q_ready;

    assign s_tready = q_ready;
    assign in_xfer  = s_tvalid && q_ready;

    hcb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .block_size (blk_size_reg),
        .accept     (in_xfer),
        .mode       (s_tuser),
        .char_in    (s_tdata),
        .msg_last   (s_tlast),
        .job_push   (job_push),
        .job        (push_job)
    );

    // Job queue decouples intake from the row engine
    logic     q_valid;
    logic     q_pop;
    hcb_job_t q_job;

    hcb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_job  (push_job),
        .in_ready  (q_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_job   (q_job)
    );

    // Back end: one matrix row per cycle unless the output stalls
    logic [6:0] letter_out;
    logic       run_last;

    hcb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enc_key    (enc_key_reg),
        .dec_key    (dec_key_reg),
        .job_valid  (q_valid),
        .job        (q_job),
        .job_pop    (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .letter_out (letter_out),
        .status     (m_tuser),
        .run_last   (run_last),
        .msg_end    (m_tlast)
    );

    assign m_tdata = {run_last, letter_out};

endmodule
`default_nettype wire

// File: design/hcb_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_front - character intake
// Folds case, checks letters, collects blocks, pads or rejects short final
// blocks, handles drop-to-end-of-message after an error, and issues jobs.
// ----------------------------------------------------------------------------
module hcb_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [1:0]        block_size,
    input  wire logic              accept,
    input  wire logic              mode,
    input  wire logic [7:0]        char_in,
    input  wire logic              msg_last,
    output logic                   job_push,
    output hcb_pkg::hcb_job_t      job
);
    import hcb_pkg::*;

    logic [CODE_W-1:0] ltr_buf_reg [KEY_DIM];
    logic [1:0]        fill_count_reg, fill_count_next;
    logic              dropping_reg, dropping_next;

    logic [1:0]        n;
    logic [7:0]        ch_fold;
    logic              is_letter;
    logic [CODE_W-1:0] code;
    logic [1:0]        fill_inc;
    logic              buf_we;

    always_comb begin
        n = (block_size == 2'd0) ? 2'd1 : block_size;
        ch_fold = char_in;
        if (!mode && char_in >= CHAR_LA && char_in <= CHAR_LZ) begin
            ch_fold = char_in - CASE_OFS;
        end
        is_letter = (ch_fold >= CHAR_A) && (ch_fold <= CHAR_Z);
        code      = CODE_W'(ch_fold - CHAR_A);
        fill_inc  = fill_count_reg + 2'd1;
    end

    always_comb begin
        job_push        = 1'b0;
        buf_we          = 1'b0;
        fill_count_next = fill_count_reg;
        dropping_next   = dropping_reg;
        job.is_err      = 1'b0;
        job.status      = ST_OK;
        job.mode        = mode;
        job.last        = msg_last;
        job.n           = n;
        // newest letter from the input, older ones from the buffer, X past fill
        for (int c = 0; c < KEY_DIM; c++) begin
            if (2'(c) == fill_count_reg) begin
                job.vec[c] = code;
            end else if (2'(c) < fill_inc) begin
                job.vec[c] = ltr_buf_reg[c];
            end else begin
                job.vec[c] = PAD_CODE;
            end
        end

        if (accept) begin
            if (dropping_reg) begin
                if (msg_last) begin
                    dropping_next   = 1'b0;
                    fill_count_next = 2'd0;
                end
            end else if (!is_letter) begin
                job_push        = 1'b1;
                job.is_err      = 1'b1;
                job.status      = ST_BAD_CHAR;
                fill_count_next = 2'd0;
                dropping_next   = !msg_last;
            end else begin
                buf_we = 1'b1;
                if (fill_inc >= n) begin
                    job_push        = 1'b1;
                    fill_count_next = 2'd0;
                end else if (msg_last) begin
                    job_push        = 1'b1;
                    fill_count_next = 2'd0;
                    if (mode) begin
                        job.is_err = 1'b1;
                        job.status = ST_BAD_LEN;
                    end
                end else begin
                    fill_count_next = fill_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_count_reg <= 2'd0;
            dropping_reg   <= 1'b0;
        end else begin
            fill_count_reg <= fill_count_next;
            dropping_reg   <= dropping_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            ltr_buf_reg[fill_count_reg] <= code;
        end
    end

endmodule
`default_nettype wire

// File: design/hcb_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_queue - job queue
// Small FIFO between front end and back end.
// ----------------------------------------------------------------------------
module hcb_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire hcb_pkg::hcb_job_t push_job,
    output logic                   in_ready,
    input  wire logic              pop,
    output logic                   out_valid,
    output hcb_pkg::hcb_job_t      out_job
);
    import hcb_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    hcb_job_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign in_ready  = (count_reg != (PTR_W+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PTR_W+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule
`default_nettype wire

// File: design/hcb_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcb_back - matrix row engine
// Walks the rows of each job, one row per cycle unless stalled: dot product in
// stage one, reduction modulo 26 and ASCII mapping into the output register.
// ----------------------------------------------------------------------------
module hcb_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic [hcb_pkg::KEY_W-1:0]  enc_key,
    input  wire logic [hcb_pkg::KEY_W-1:0]  dec_key,
    input  wire logic                       job_valid,
    input  wire hcb_pkg::hcb_job_t          job,
    output logic                            job_pop,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [6:0]                      letter_out,
    output logic [1:0]                      status,
    output logic                            run_last,
    output logic                            msg_end
);
    import hcb_pkg::*;

    logic [1:0]       row_reg;
    logic             a_vld_reg;
    logic [ACC_W-1:0] a_acc_reg;
    logic [1:0]       a_status_reg;
    logic             a_run_last_reg, a_msg_end_reg;
    logic             m_vld_reg;
    logic [6:0]       m_letter_reg;
    logic [1:0]       m_status_reg;
    logic             m_run_last_reg, m_msg_end_reg;

    logic             adv_a, adv_b, issue, row_last;
    logic [KEY_W-1:0] key;
    logic [ROW_W-1:0] key_row;
    logic [ACC_W-1:0] acc;
    logic [23:0]      recip_prod;
    logic [6:0]       quot;
    logic [ACC_W-1:0] quot_x26;
    logic [CODE_W-1:0] rem;

    assign adv_b    = !m_vld_reg || m_tready;
    assign adv_a    = !a_vld_reg || adv_b;
    assign issue    = job_valid && adv_a;
    assign row_last = job.is_err || (row_reg == job.n - 2'd1);
    assign job_pop  = issue && row_last;

    always_comb begin
        key = job.mode ? dec_key : enc_key;
        case (row_reg)
            2'd0:    key_row = key[0       +: ROW_W];
            2'd1:    key_row = key[ROW_W   +: ROW_W];
            2'd2:    key_row = key[2*ROW_W +: ROW_W];
            default: key_row = '0;
        endcase
        acc = '0;
        for (int c = 0; c < KEY_DIM; c++) begin
            if (2'(c) < job.n) begin
                acc = acc + ACC_W'(PROD_W'(key_row[c*CODE_W +: CODE_W])
                                   * PROD_W'(job.vec[c]));
            end
        end
    end

    always_comb begin
        recip_prod = 24'(a_acc_reg) * RECIP_26;
        quot       = 7'(recip_prod >> 16);
        quot_x26   = ACC_W'({quot, 4'b0}) + ACC_W'({quot, 3'b0}) + ACC_W'({quot, 1'b0});
        rem        = CODE_W'(a_acc_reg - quot_x26);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg   <= 2'd0;
            a_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
        end else begin
            if (issue) begin
                row_reg <= row_last ? 2'd0 : row_reg + 2'd1;
            end
            if (adv_a) begin
                a_vld_reg <= issue;
            end
            if (adv_b) begin
                m_vld_reg <= a_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_a) begin
            a_acc_reg      <= acc;
            a_status_reg   <= job.status;
            a_run_last_reg <= row_last;
            a_msg_end_reg  <= job.is_err || (row_last && job.last);
        end
        if (adv_b) begin
            m_letter_reg   <= (a_status_reg == ST_OK) ? LETTER_BASE + 7'(rem) : 7'd0;
            m_status_reg   <= a_status_reg;
            m_run_last_reg <= a_run_last_reg;
            m_msg_end_reg  <= a_msg_end_reg;
        end
    end

    assign m_tvalid   = m_vld_reg;
    assign letter_out = m_letter_reg;
    assign status     = m_status_reg;
    assign run_last   = m_run_last_reg;
    assign msg_end    = m_msg_end_reg;

endmodule
`default_nettype wire
